// ----- rtl/fnps_pkg.sv -----
package fnps_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int DIFF_W      = 25;
    localparam int SQ_W        = 48;
    localparam int DIST_W      = 50;

    typedef enum logic [1:0] {
        ST_APPENDED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_NONE     = 2'd3
    } t_status;

    typedef enum logic {
        FN_APPEND = 1'b0,
        FN_QUERY  = 1'b1
    } t_func;

    typedef struct packed {
        logic [31:0]        entry_id;
        logic [31:0]        map_number;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [23:0] pos_z;
        logic [7:0]         group_tag;
        logic [31:0]        zone_number;
    } t_entry;

    typedef struct packed {
        t_func  func;
        t_entry ent;
    } t_in_word;

    typedef struct packed {
        t_status status;
        t_entry  found;
    } t_out_word;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic scan_issue;
        logic fetch;
        logic append;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
    } t_sts;

endpackage

// ----- rtl/fnps_if.sv -----
interface fnps_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic [31:0]        entry_id;
    logic [31:0]        map_number;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [7:0]         group_tag;
    logic [31:0]        zone_number;

    modport source (
        output valid, func, entry_id, map_number, pos_x, pos_y, pos_z,
               group_tag, zone_number,
        input  ready
    );
    modport sink (
        input  valid, func, entry_id, map_number, pos_x, pos_y, pos_z,
               group_tag, zone_number,
        output ready
    );
endinterface

interface fnps_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        found_id;
    logic [31:0]        found_map;
    logic signed [23:0] found_x;
    logic signed [23:0] found_y;
    logic signed [23:0] found_z;
    logic [7:0]         found_group;
    logic [31:0]        found_zone;

    modport source (
        output valid, status, found_id, found_map, found_x, found_y, found_z,
               found_group, found_zone,
        input  ready
    );
    modport sink (
        input  valid, status, found_id, found_map, found_x, found_y, found_z,
               found_group, found_zone,
        output ready
    );
endinterface

// ----- rtl/fnps_ctrl.sv -----
module fnps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_func,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  fnps_pkg::t_sts i_sts,
    output fnps_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_DRAIN,
        S_FETCH,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_in_func == fnps_pkg::FN_QUERY) ? S_SCAN : S_APPEND;
                end
            end
            S_APPEND: begin
                if (w_out_free) begin
                    o_cmd.append = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan_issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.append || o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/fnps_dp.sv -----
module fnps_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fnps_pkg::t_in_word  i_word,
    input  fnps_pkg::t_cmd      i_cmd,
    output fnps_pkg::t_sts      o_sts,
    output fnps_pkg::t_out_word o_word
);

    // Entry table and its registered read port.
    fnps_pkg::t_entry r_mem [fnps_pkg::MAX_ENTRIES];
    fnps_pkg::t_entry r_rd;

    fnps_pkg::t_in_word           r_q;
    logic [fnps_pkg::CNT_W-1:0]   r_count;
    logic [fnps_pkg::CNT_W-1:0]   r_scan_addr;
    logic [fnps_pkg::IDX_W-1:0]   w_rd_addr;
    logic                         w_rd_en;
    logic                         w_full;

    // Scan pipeline: read, difference, square, sum, compare.
    logic                                r_v1, r_v2, r_v3, r_v4;
    logic                                r_m2, r_m3, r_m4;
    logic [fnps_pkg::IDX_W-1:0]          r_i1, r_i2, r_i3, r_i4;
    logic signed [fnps_pkg::DIFF_W-1:0]  r_dx, r_dy, r_dz;
    logic signed [2*fnps_pkg::DIFF_W-1:0] w_px, w_py, w_pz;
    logic [fnps_pkg::SQ_W-1:0]           r_sx, r_sy, r_sz;
    logic [fnps_pkg::DIST_W-1:0]         r_sum;

    logic                         r_have;
    logic [fnps_pkg::DIST_W-1:0]  r_best_d;
    logic [fnps_pkg::IDX_W-1:0]   r_best_i;

    fnps_pkg::t_out_word r_out;

    assign w_full    = (r_count == fnps_pkg::CNT_W'(fnps_pkg::MAX_ENTRIES));
    assign w_rd_en   = i_cmd.scan_issue || i_cmd.fetch;
    assign w_rd_addr = i_cmd.fetch ? r_best_i : r_scan_addr[fnps_pkg::IDX_W-1:0];

    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    assign o_sts.scan_done = (r_scan_addr == r_count);
    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_word          = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !w_full) begin
            r_mem[r_count[fnps_pkg::IDX_W-1:0]] <= r_q.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_q <= i_word;
        end
        r_i1 <= r_scan_addr[fnps_pkg::IDX_W-1:0];
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        r_dx <= fnps_pkg::DIFF_W'(r_rd.pos_x) - fnps_pkg::DIFF_W'(r_q.ent.pos_x);
        r_dy <= fnps_pkg::DIFF_W'(r_rd.pos_y) - fnps_pkg::DIFF_W'(r_q.ent.pos_y);
        r_dz <= fnps_pkg::DIFF_W'(r_rd.pos_z) - fnps_pkg::DIFF_W'(r_q.ent.pos_z);
        r_m2 <= (r_rd.map_number == r_q.ent.map_number)
                && ((r_rd.group_tag == 8'd0) || (r_rd.group_tag == r_q.ent.group_tag));
        r_m3 <= r_m2;
        r_m4 <= r_m3;
        r_sx <= w_px[fnps_pkg::SQ_W-1:0];
        r_sy <= w_py[fnps_pkg::SQ_W-1:0];
        r_sz <= w_pz[fnps_pkg::SQ_W-1:0];
        r_sum <= fnps_pkg::DIST_W'(r_sx) + fnps_pkg::DIST_W'(r_sy)
                 + fnps_pkg::DIST_W'(r_sz);
        if (r_v4 && r_m4 && (!r_have || (r_sum < r_best_d))) begin
            r_best_d <= r_sum;
            r_best_i <= r_i4;
        end
        if (i_cmd.append) begin
            r_out.status <= w_full ? fnps_pkg::ST_FULL : fnps_pkg::ST_APPENDED;
            r_out.found  <= '0;
        end else if (i_cmd.finish) begin
            r_out.status <= r_have ? fnps_pkg::ST_FOUND : fnps_pkg::ST_NONE;
            r_out.found  <= r_have ? r_rd : '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan_addr <= '0;
            r_have      <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_cmd.capture) begin
                r_scan_addr <= '0;
                r_have      <= 1'b0;
            end else begin
                if (i_cmd.scan_issue) begin
                    r_scan_addr <= r_scan_addr + 1'b1;
                end
                if (r_v4 && r_m4) begin
                    r_have <= 1'b1;
                end
            end
            if (i_cmd.append && !w_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/filtered_nearest_point_search.sv -----
// Nearest stored point search. The block holds a table of up to 256 entries, each a
// 3-D position (signed, 8 fraction bits) with an id, map number, group tag and zone.
// An append word stores one entry at the end of the table, or reports the table as
// full and drops it. Its result is loaded into the output register once that register
// is free, and the block then goes back to idle for the next word. A query word scans
// every stored entry in load order, one entry per cycle through the single read port
// of the entry table. It keeps entries on the requested map whose tag is zero or the
// requested group, and returns the entry nearest by exact squared distance, the
// earliest on ties, or reports that none matched. In order, a query reads the entries,
// sees the end of the table, waits while the difference, square, sum and compare
// pipeline drains, fetches the winning entry and loads the result. The next word is
// taken once the result is loaded and the block is back in idle. One word is worked
// on at a time. The result sits in an output register, so the next word is accepted
// while the result waits; its own result is loaded, and an append's table write done,
// once the register frees. The table has no reset of its own: only entries already
// written are scanned.
module filtered_nearest_point_search (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fnps_in_if.sink    i_in,
    fnps_out_if.source o_out
);

    fnps_pkg::t_in_word  w_in_word;
    fnps_pkg::t_out_word w_out_word;
    fnps_pkg::t_cmd      w_cmd;
    fnps_pkg::t_sts      w_sts;
    logic                w_in_ready;
    logic                w_out_valid;

    // Gather the input word into one structure for the datapath.
    assign w_in_word.func            = fnps_pkg::t_func'(i_in.func);
    assign w_in_word.ent.entry_id    = i_in.entry_id;
    assign w_in_word.ent.map_number  = i_in.map_number;
    assign w_in_word.ent.pos_x       = i_in.pos_x;
    assign w_in_word.ent.pos_y       = i_in.pos_y;
    assign w_in_word.ent.pos_z       = i_in.pos_z;
    assign w_in_word.ent.group_tag   = i_in.group_tag;
    assign w_in_word.ent.zone_number = i_in.zone_number;

    assign i_in.ready = w_in_ready;

    // The sequencer: accepts a word, steps the scan and loads the result register.
    fnps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_func   (i_in.func),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The entry table, distance pipeline, best-entry tracking and result register.
    fnps_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (w_in_word),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_word  (w_out_word)
    );

    assign o_out.valid       = w_out_valid;
    assign o_out.status      = w_out_word.status;
    assign o_out.found_id    = w_out_word.found.entry_id;
    assign o_out.found_map   = w_out_word.found.map_number;
    assign o_out.found_x     = w_out_word.found.pos_x;
    assign o_out.found_y     = w_out_word.found.pos_y;
    assign o_out.found_z     = w_out_word.found.pos_z;
    assign o_out.found_group = w_out_word.found.group_tag;
    assign o_out.found_zone  = w_out_word.found.zone_number;

    // A new word is only taken once the previous scan has fully drained.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !w_sts.pipe_busy)
        else $error("input taken while the scan pipeline is still busy");

    // The scan never reads beyond the entries that have been written.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_issue |-> !w_sts.scan_done)
        else $error("scan read issued past the filled part of the table");

    // At most one command is given to the datapath in any cycle.
    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.capture, w_cmd.scan_issue, w_cmd.fetch,
                  w_cmd.append, w_cmd.finish}))
        else $error("more than one datapath command at once");

    // Results of appends and of queries with no match carry no entry.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != fnps_pkg::ST_FOUND))
        |-> (o_out.found_id == 32'd0 && o_out.found_map == 32'd0
             && o_out.found_zone == 32'd0 && o_out.found_group == 8'd0))
        else $error("result without a match carries entry data");

endmodule
